// ===== sv/utf8_sanitize_replace_unit_macros.svh =====
// Assertion helpers for the UTF-8 sanitizer; all sample on clk_i and stay off during reset.
`ifndef UTF8_SANITIZE_REPLACE_UNIT_MACROS_SVH
`define UTF8_SANITIZE_REPLACE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UTF8S_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UTF8S_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/utf8s_pkg.sv =====
package utf8s_pkg;

  typedef logic [7:0] byte_t;

  // Work descriptor from front to back: replacements first, then plain bytes.
  typedef struct packed {
    logic             last;     // input beat closed the string
    logic [2:0]       rep_cnt;  // number of EF BF BD triples, 0-4
    logic [2:0]       dat_cnt;  // number of pass-through bytes, 0-4
    logic [3:0][7:0]  dat;      // pass-through bytes, index 0 first
  } cmd_t;

endpackage

// ===== sv/utf8_sanitize_replace_unit.sv =====
// Strict UTF-8 sanitizer: raw bytes in, well-formed UTF-8 out.
// Slave stream: one raw byte per beat in tdata, tlast marks the last byte of a string.
// Master stream: one output byte per beat; tlast marks the last byte caused by one
// input beat, tuser marks the final byte of the whole string.
// Malformed bytes are replaced by EF BF BD; a byte that breaks an open sequence
// replaces each held byte and is then decoded again as a fresh start.
// The first output byte of an input beat passes through the descriptor queue and then the output register.
// Throughput: one output byte per cycle while m_axis_tready_i is high, set by the single
// output register; an input beat that expands to up to 12 bytes holds the back end until its
// last byte is loaded, while the front keeps accepting until the QUEUE_DEPTH-entry queue is full.
// Bytes that only extend an open sequence produce no output.
// Reset empties the queue, drops any open sequence and clears the output register.
// A stall on m_axis_tready_i holds the output beat; the queue then fills and
// s_axis_tready_o falls until the back end moves again.
`include "utf8_sanitize_replace_unit_macros.svh"

module utf8_sanitize_replace_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] stream_end
);

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_valid;
  logic             front_empty;
  logic             last_fire;
  logic             end_beat;
  logic             idle_work;
  utf8s_pkg::cmd_t  push_cmd;
  utf8s_pkg::cmd_t  head_cmd;

  // Classification and sequence tracking
  utf8s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (q_full),
    .empty_o    (front_empty)
  );

  // Descriptor queue
  utf8s_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head_cmd)
  );

  // Byte emitter
  utf8s_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_end_o    (m_axis_tuser_o)
  );

  // Terms watched by the checks below
  assign last_fire = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign end_beat  = m_axis_tvalid_o && m_axis_tuser_o;
  assign idle_work = q_valid && !m_axis_tvalid_o;

  // End of string always closes the run of its input beat
  `UTF8S_ASSERT_SAME(a_end_is_last, end_beat, m_axis_tlast_o, "stream end without run end")
  // The last byte of a string leaves no open sequence behind
  `UTF8S_ASSERT_NEXT(a_last_clears_hold, last_fire, front_empty, "sequence held after last byte")
  // Queued work reaches an empty output register in the next cycle
  `UTF8S_ASSERT_NEXT(a_queue_drains, idle_work, m_axis_tvalid_o, "queued work not moved out")

endmodule

// ===== sv/utf8s_front.sv =====
module utf8s_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  utf8s_pkg::byte_t    in_byte_i,
  input  logic                in_last_i,
  output logic                push_o,
  output utf8s_pkg::cmd_t     cmd_o,
  input  logic                full_i,
  output logic                empty_o
);

  localparam utf8s_pkg::byte_t AsciiMax = 8'h7F;
  localparam utf8s_pkg::byte_t ContLo   = 8'h80;
  localparam utf8s_pkg::byte_t ContHi   = 8'hBF;
  localparam utf8s_pkg::byte_t Lead2Lo  = 8'hC2;
  localparam utf8s_pkg::byte_t Lead2Hi  = 8'hDF;
  localparam utf8s_pkg::byte_t Lead3Lo  = 8'hE0;
  localparam utf8s_pkg::byte_t Lead3Hi  = 8'hEF;
  localparam utf8s_pkg::byte_t Lead4Lo  = 8'hF0;
  localparam utf8s_pkg::byte_t Lead4Hi  = 8'hF4;
  localparam utf8s_pkg::byte_t LeadE0   = 8'hE0;
  localparam utf8s_pkg::byte_t LeadED   = 8'hED;
  localparam utf8s_pkg::byte_t LeadF0   = 8'hF0;
  localparam utf8s_pkg::byte_t LeadF4   = 8'hF4;
  localparam utf8s_pkg::byte_t E0SecLo  = 8'hA0;
  localparam utf8s_pkg::byte_t EDSecHi  = 8'h9F;
  localparam utf8s_pkg::byte_t F0SecLo  = 8'h90;
  localparam utf8s_pkg::byte_t F4SecHi  = 8'h8F;

  utf8s_pkg::byte_t held_q [3];
  utf8s_pkg::byte_t held_d [3];
  logic [1:0]       hcnt_q, hcnt_d;
  logic [2:0]       need_q, need_d;

  utf8s_pkg::byte_t lo, hi;
  logic             fits;
  logic             is_ascii;
  logic [2:0]       lead_len;
  logic             start;
  logic             accept;
  utf8s_pkg::cmd_t  cmd;

  // Continuation range, narrowed on the second byte for special leads
  always_comb begin
    lo = ContLo;
    hi = ContHi;
    if (hcnt_q == 2'd1) begin
      unique case (held_q[0])
        LeadE0:  lo = E0SecLo;
        LeadED:  hi = EDSecHi;
        LeadF0:  lo = F0SecLo;
        LeadF4:  hi = F4SecHi;
        default: begin
        end
      endcase
    end
  end

  assign fits     = (in_byte_i >= lo) && (in_byte_i <= hi);
  assign is_ascii = in_byte_i <= AsciiMax;

  // Lead classification; zero means not a valid lead
  always_comb begin
    lead_len = 3'd0;
    priority if (in_byte_i >= Lead2Lo && in_byte_i <= Lead2Hi) begin
      lead_len = 3'd2;
    end else if (in_byte_i >= Lead3Lo && in_byte_i <= Lead3Hi) begin
      lead_len = 3'd3;
    end else if (in_byte_i >= Lead4Lo && in_byte_i <= Lead4Hi) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  // Sequence tracking and descriptor build
  always_comb begin
    held_d   = held_q;
    hcnt_d   = hcnt_q;
    need_d   = need_q;
    cmd      = '0;
    cmd.last = in_last_i;
    start    = 1'b0;
    if (hcnt_q == 2'd0) begin
      start = 1'b1;
    end else if (fits) begin
      if (({1'b0, hcnt_q} + 3'd1) >= need_q) begin
        // sequence complete: held bytes then this one
        cmd.dat[0]  = held_q[0];
        cmd.dat[1]  = (hcnt_q == 2'd1) ? in_byte_i : held_q[1];
        cmd.dat[2]  = (hcnt_q == 2'd2) ? in_byte_i : held_q[2];
        cmd.dat[3]  = in_byte_i;
        cmd.dat_cnt = {1'b0, hcnt_q} + 3'd1;
        hcnt_d      = 2'd0;
        need_d      = 3'd0;
      end else begin
        held_d[hcnt_q] = in_byte_i;
        hcnt_d         = hcnt_q + 2'd1;
      end
    end else begin
      // broken sequence: each held byte is replaced, byte is looked at again
      cmd.rep_cnt = {1'b0, hcnt_q};
      hcnt_d      = 2'd0;
      need_d      = 3'd0;
      start       = 1'b1;
    end
    if (start) begin
      if (is_ascii) begin
        cmd.dat[0]  = in_byte_i;
        cmd.dat_cnt = 3'd1;
      end else if (lead_len != 3'd0) begin
        held_d[0] = in_byte_i;
        hcnt_d    = 2'd1;
        need_d    = lead_len;
      end else begin
        cmd.rep_cnt = cmd.rep_cnt + 3'd1;
      end
    end
    // end of string flushes whatever is still open
    if (in_last_i) begin
      cmd.rep_cnt = cmd.rep_cnt + {1'b0, hcnt_d};
      hcnt_d      = 2'd0;
      need_d      = 3'd0;
    end
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && ((cmd.rep_cnt != 3'd0) || (cmd.dat_cnt != 3'd0));
  assign cmd_o      = cmd;
  assign empty_o    = hcnt_q == 2'd0;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 2'd0;
      need_q <= 3'd0;
    end else if (accept) begin
      hcnt_q <= hcnt_d;
      need_q <= need_d;
    end
  end

  // Held bytes, valid only below the count
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== sv/utf8s_fifo.sv =====
module utf8s_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8s_pkg::cmd_t  cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output utf8s_pkg::cmd_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utf8s_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/utf8s_back.sv =====
module utf8s_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  utf8s_pkg::cmd_t     head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output utf8s_pkg::byte_t    out_byte_o,
  output logic                out_last_o,
  output logic                out_end_o
);

  typedef enum logic [1:0] {PH_EF, PH_BF, PH_BD} ph_e;

  logic [2:0]        rdone_q;
  ph_e               ph_q;
  logic [1:0]        di_q;
  logic              out_valid_q;
  utf8s_pkg::byte_t  out_byte_q;
  logic              out_last_q, out_end_q;

  logic              in_rep;
  logic              is_final;
  logic              load;
  utf8s_pkg::byte_t  repl;
  utf8s_pkg::byte_t  cur_byte;

  // Replacement character U+FFFD, one byte per phase
  always_comb begin
    unique case (ph_q)
      PH_EF:   repl = 8'hEF;
      PH_BF:   repl = 8'hBF;
      PH_BD:   repl = 8'hBD;
      default: repl = 8'hEF;
    endcase
  end

  assign in_rep   = rdone_q < head_i.rep_cnt;
  assign cur_byte = in_rep ? repl : head_i.dat[di_q];
  assign is_final = in_rep
                  ? ((ph_q == PH_BD) && ((rdone_q + 3'd1) == head_i.rep_cnt)
                     && (head_i.dat_cnt == 3'd0))
                  : (({1'b0, di_q} + 3'd1) == head_i.dat_cnt);

  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && is_final;

  // Position within the current descriptor and the output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdone_q     <= 3'd0;
      ph_q        <= PH_EF;
      di_q        <= 2'd0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_end_q   <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        out_byte_q <= cur_byte;
        out_last_q <= is_final;
        out_end_q  <= is_final && head_i.last;
        if (is_final) begin
          rdone_q <= 3'd0;
          ph_q    <= PH_EF;
          di_q    <= 2'd0;
        end else if (in_rep) begin
          unique case (ph_q)
            PH_EF:   ph_q <= PH_BF;
            PH_BF:   ph_q <= PH_BD;
            default: begin
              ph_q    <= PH_EF;
              rdone_q <= rdone_q + 3'd1;
            end
          endcase
        end else begin
          di_q <= di_q + 2'd1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_end_o   = out_end_q;

endmodule
